// File: sv/bns_pkg.sv
`default_nettype none
package bns_pkg;

    localparam int unsigned COORD_W  = 20;
    localparam int unsigned RADIUS_W = 12;
    localparam int unsigned SCALE_W  = 10;
    localparam int unsigned QIDX_W   = 10;
    localparam int unsigned NIDX_W   = 10;
    localparam int unsigned LEN_W    = 20;
    localparam int unsigned MODE_W   = 2;
    localparam int unsigned DIFF_W   = COORD_W + 1;
    localparam int unsigned MOP_W    = 23;
    localparam int unsigned PROD_W   = 2 * MOP_W;
    localparam int unsigned DIST2_W  = 42;
    localparam int unsigned ROOT_W   = DIST2_W / 2;
    localparam int unsigned CMP_W    = DIST2_W + 16;
    localparam int unsigned PADDR_W  = 3;

    localparam logic [SCALE_W-1:0] SCALE_RESET = SCALE_W'(256);
    localparam logic [LEN_W-1:0]   LEN_MAX     = '1;

    localparam logic [MODE_W-1:0] MODE_APPEND = 2'd0;
    localparam logic [MODE_W-1:0] MODE_QUERY  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_CLEAR  = 2'd2;

    typedef logic [MODE_W-1:0]          t_mode;
    typedef logic signed [COORD_W-1:0]  t_coord;
    typedef logic [RADIUS_W-1:0]        t_radius;

    typedef struct packed {
        t_coord  x;
        t_coord  y;
        t_coord  z;
        t_radius radius;
    } t_atom;

    typedef struct packed {
        logic [NIDX_W-1:0] idx;
        logic [LEN_W-1:0]  len;
    } t_bond;

endpackage
`default_nettype wire

// File: sv/bns_if.sv
`default_nettype none
interface bns_in_if;
    import bns_pkg::*;
    logic                        valid;
    logic                        ready;
    logic [MODE_W-1:0]           mode;
    logic signed [COORD_W-1:0]   pos_x;
    logic signed [COORD_W-1:0]   pos_y;
    logic signed [COORD_W-1:0]   pos_z;
    logic [RADIUS_W-1:0]         atom_radius;
    logic [QIDX_W-1:0]           query_index;
    modport source (output valid, mode, pos_x, pos_y, pos_z, atom_radius, query_index,
                    input ready);
    modport sink (input valid, mode, pos_x, pos_y, pos_z, atom_radius, query_index,
                  output ready);
endinterface

interface bns_out_if;
    import bns_pkg::*;
    logic               valid;
    logic               ready;
    logic [NIDX_W-1:0]  neighbor_index;
    logic [LEN_W-1:0]   bond_length;
    logic               bond_valid;
    logic               overflow;
    logic               last_bond;
    modport source (output valid, neighbor_index, bond_length, bond_valid, overflow,
                    last_bond, input ready);
    modport sink (input valid, neighbor_index, bond_length, bond_valid, overflow,
                  last_bond, output ready);
endinterface
`default_nettype wire

// File: sv/bns_atom_store.sv
`default_nettype none
module bns_atom_store #(
    parameter int unsigned DEPTH = 1024,
    parameter int unsigned AW    = 10
) (
    input  wire logic           i_clk,
    input  wire logic           i_wr_en,
    input  wire logic [AW-1:0]  i_wr_addr,
    input  wire bns_pkg::t_atom i_wr_data,
    input  wire logic           i_rd_en,
    input  wire logic [AW-1:0]  i_rd_addr,
    output bns_pkg::t_atom      o_rd_data
);
    import bns_pkg::*;

    t_atom r_mem [DEPTH];
    t_atom r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule
`default_nettype wire

// File: sv/bns_isqrt.sv
`default_nettype none
module bns_isqrt (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_start,
    input  wire logic [bns_pkg::DIST2_W-1:0]  i_x,
    output logic                              o_done,
    output logic [bns_pkg::ROOT_W-1:0]        o_root
);
    import bns_pkg::*;

    localparam int unsigned REM_W = ROOT_W + 3;
    localparam int unsigned CNT_W = $clog2(ROOT_W + 1);

    logic [DIST2_W-1:0] r_x;
    logic [REM_W-1:0]   r_rem;
    logic [ROOT_W-1:0]  r_root;
    logic [CNT_W-1:0]   r_cnt;
    logic               r_busy;
    logic               r_done;

    logic [REM_W+1:0]   sh;
    logic [REM_W+1:0]   trial;
    logic               take;

    // two radicand bits per step, one root bit out
    assign sh    = {r_rem, r_x[DIST2_W-1 -: 2]};
    assign trial = (REM_W + 2)'({r_root, 2'b01});
    assign take  = (sh >= trial);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_cnt == CNT_W'(1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_x    <= i_x;
            r_rem  <= '0;
            r_root <= '0;
            r_cnt  <= CNT_W'(ROOT_W);
        end else if (r_busy) begin
            r_x    <= r_x << 2;
            r_rem  <= take ? REM_W'(sh - trial) : REM_W'(sh);
            r_root <= {r_root[ROOT_W-2:0], take};
            r_cnt  <= r_cnt - CNT_W'(1);
        end
    end

    assign o_done = r_done;
    assign o_root = r_root;

endmodule
`default_nettype wire

// File: sv/bond_neighbor_search.sv
`default_nettype none
// Bond search over a store of atoms. mode 0 appends an atom (ignored once the store
// is full), mode 2 empties the store, mode 3 is ignored; these give no word. mode 1
// scans every other stored atom in ascending index order with a single shared 23x23
// multiplier, which forms the three squared coordinate differences, the scaled radius
// sum and its square, through the states RD, DX, DY, DZ, SC, SQ and CMP for each
// stored atom; the queried atom itself passes through RD only. Each hit kept then
// goes through the bit-serial square root.
// The bonds are buffered and sent once the scan ends (so the overflow flag is known),
// one word at a time through the states ERD and EWR, each word waiting until the
// receiver has taken the one before; an atom with no bond, or an index past the end
// of the store, gives one word with bond_valid low.
// Input ready is high only while no query is running.
// bond_scale is written through the APB port at any address with paddr[2] low (0 to 3).
module bond_neighbor_search #(
    parameter int unsigned MAX_ATOMS = 1024,
    parameter int unsigned MAX_BONDS = 16
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    bns_in_if.sink                             i_in,
    bns_out_if.source                          o_out,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [bns_pkg::PADDR_W-1:0]   paddr,
    input  wire logic [31:0]                   pwdata,
    output logic [31:0]                        prdata,
    output logic                               pready
);
    import bns_pkg::*;

    localparam int unsigned AW  = (MAX_ATOMS > 1) ? $clog2(MAX_ATOMS) : 1;
    localparam int unsigned CW  = $clog2(MAX_ATOMS + 1);
    localparam int unsigned NBW = $clog2(MAX_BONDS + 1);
    localparam int unsigned BW  = (MAX_BONDS > 1) ? $clog2(MAX_BONDS) : 1;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_QRD   = 4'd1;
    localparam logic [3:0] S_QLD   = 4'd2;
    localparam logic [3:0] S_RD    = 4'd3;
    localparam logic [3:0] S_DX    = 4'd4;
    localparam logic [3:0] S_DY    = 4'd5;
    localparam logic [3:0] S_DZ    = 4'd6;
    localparam logic [3:0] S_SC    = 4'd7;
    localparam logic [3:0] S_SQ    = 4'd8;
    localparam logic [3:0] S_CMP   = 4'd9;
    localparam logic [3:0] S_SQRT  = 4'd10;
    localparam logic [3:0] S_EMPTY = 4'd11;
    localparam logic [3:0] S_ERD   = 4'd12;
    localparam logic [3:0] S_EWR   = 4'd13;

    logic [3:0]          r_state;
    logic [SCALE_W-1:0]  r_scale;
    logic [CW-1:0]       r_count;
    logic [AW-1:0]       r_qi;
    logic [AW-1:0]       r_j;
    t_atom               r_q;
    logic [DIST2_W-1:0]  r_d2;
    logic [PROD_W-1:0]   r_prod;
    logic [NBW-1:0]      r_nb;
    logic [NBW-1:0]      r_oi;
    logic                r_ovf;
    t_bond               r_buf [MAX_BONDS];
    t_bond               r_buf_rd;

    logic                r_ov;
    logic [NIDX_W-1:0]   r_o_idx;
    logic [LEN_W-1:0]    r_o_len;
    logic                r_o_bv;
    logic                r_o_ovf;
    logic                r_o_last;

    logic                in_acc;
    logic                cfg_wr;
    logic                st_wr;
    logic                st_rd;
    logic [AW-1:0]       st_rd_addr;
    t_atom               st_wr_data;
    t_atom               st_rd_data;
    logic                at_end;
    logic                hit;
    logic [MOP_W-1:0]    op_a;
    logic [MOP_W-1:0]    op_b;
    logic [DIFF_W-1:0]   mag;
    logic signed [DIFF_W-1:0] dq;
    logic signed [DIFF_W-1:0] dj;
    logic signed [DIFF_W-1:0] diff;
    logic                sq_start;
    logic                sq_done;
    logic [ROOT_W-1:0]   sq_root;
    logic [LEN_W-1:0]    len_sat;
    logic [31:0]         j_wide;
    logic [31:0]         qi_wide;

    assign in_acc  = i_in.valid && i_in.ready;
    assign i_in.ready = (r_state == S_IDLE);
    assign cfg_wr  = psel && penable && pwrite && (paddr[PADDR_W-1] == 1'b0);
    assign pready  = 1'b1;
    assign prdata  = (paddr[PADDR_W-1] == 1'b0) ? 32'(r_scale) : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scale <= SCALE_RESET;
        end else if (cfg_wr) begin
            r_scale <= pwdata[SCALE_W-1:0];
        end
    end

    // store access
    assign st_wr = in_acc && (i_in.mode == MODE_APPEND) && (r_count != CW'(MAX_ATOMS));
    assign st_wr_data = '{x: i_in.pos_x, y: i_in.pos_y, z: i_in.pos_z,
                          radius: i_in.atom_radius};
    assign st_rd      = (r_state == S_QRD) || (r_state == S_RD);
    assign st_rd_addr = (r_state == S_QRD) ? r_qi : r_j;

    bns_atom_store #(.DEPTH(MAX_ATOMS), .AW(AW)) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (st_wr),
        .i_wr_addr (r_count[AW-1:0]),
        .i_wr_data (st_wr_data),
        .i_rd_en   (st_rd),
        .i_rd_addr (st_rd_addr),
        .o_rd_data (st_rd_data)
    );

    // shared multiplier operand select
    always_comb begin
        dq = '0;
        dj = '0;
        unique case (r_state)
            S_DX: begin
                dq = DIFF_W'(r_q.x);
                dj = DIFF_W'(st_rd_data.x);
            end
            S_DY: begin
                dq = DIFF_W'(r_q.y);
                dj = DIFF_W'(st_rd_data.y);
            end
            S_DZ: begin
                dq = DIFF_W'(r_q.z);
                dj = DIFF_W'(st_rd_data.z);
            end
            default: begin
                dq = '0;
                dj = '0;
            end
        endcase
        diff = dq - dj;
        mag  = diff[DIFF_W-1] ? DIFF_W'(-diff) : DIFF_W'(diff);
        unique case (r_state)
            S_SC: begin
                op_a = MOP_W'(r_scale);
                op_b = MOP_W'({1'b0, r_q.radius} + {1'b0, st_rd_data.radius});
            end
            S_SQ: begin
                op_a = r_prod[MOP_W-1:0];
                op_b = r_prod[MOP_W-1:0];
            end
            default: begin
                op_a = MOP_W'(mag);
                op_b = MOP_W'(mag);
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_prod <= op_a * op_b;
    end

    assign hit     = ({r_d2, 16'd0} < CMP_W'(r_prod));
    assign at_end  = ((CW'(r_j) + CW'(1)) == r_count);
    assign sq_start = (r_state == S_CMP) && hit && (r_nb != NBW'(MAX_BONDS));
    assign len_sat = (sq_root > ROOT_W'(LEN_MAX)) ? LEN_MAX : sq_root[LEN_W-1:0];
    assign j_wide  = 32'(r_j);
    assign qi_wide = 32'(i_in.query_index);

    bns_isqrt u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (sq_start),
        .i_x     (r_d2),
        .o_done  (sq_done),
        .o_root  (sq_root)
    );

    // bond buffer
    always_ff @(posedge i_clk) begin
        if (r_state == S_SQRT && sq_done) begin
            r_buf[r_nb[BW-1:0]] <= '{idx: j_wide[NIDX_W-1:0], len: len_sat};
        end
        if (r_state == S_ERD) begin
            r_buf_rd <= r_buf[r_oi[BW-1:0]];
        end
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_ov    <= 1'b0;
        end else begin
            if (o_out.valid && o_out.ready) begin
                r_ov <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        priority if (i_in.mode == MODE_APPEND) begin
                            if (st_wr) begin
                                r_count <= r_count + CW'(1);
                            end
                        end else if (i_in.mode == MODE_CLEAR) begin
                            r_count <= '0;
                        end else if (i_in.mode == MODE_QUERY) begin
                            r_qi  <= qi_wide[AW-1:0];
                            r_j   <= '0;
                            r_nb  <= '0;
                            r_ovf <= 1'b0;
                            if (qi_wide < 32'(r_count)) begin
                                r_state <= S_QRD;
                            end else begin
                                r_state <= S_EMPTY;
                            end
                        end else begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                S_QRD: r_state <= S_QLD;
                S_QLD: begin
                    r_q     <= st_rd_data;
                    r_state <= S_RD;
                end
                S_RD: begin
                    if (r_j == r_qi) begin
                        if (at_end) begin
                            r_oi    <= '0;
                            r_state <= (r_nb == '0) ? S_EMPTY : S_ERD;
                        end else begin
                            r_j <= r_j + AW'(1);
                        end
                    end else begin
                        r_state <= S_DX;
                    end
                end
                S_DX: r_state <= S_DY;
                S_DY: begin
                    r_d2    <= DIST2_W'(r_prod);
                    r_state <= S_DZ;
                end
                S_DZ: begin
                    r_d2    <= r_d2 + DIST2_W'(r_prod);
                    r_state <= S_SC;
                end
                S_SC: begin
                    r_d2    <= r_d2 + DIST2_W'(r_prod);
                    r_state <= S_SQ;
                end
                S_SQ: r_state <= S_CMP;
                S_CMP: begin
                    if (sq_start) begin
                        r_state <= S_SQRT;
                    end else begin
                        if (hit) begin
                            r_ovf <= 1'b1;
                        end
                        if (at_end) begin
                            r_oi    <= '0;
                            r_state <= (r_nb == '0) ? S_EMPTY : S_ERD;
                        end else begin
                            r_j     <= r_j + AW'(1);
                            r_state <= S_RD;
                        end
                    end
                end
                S_SQRT: begin
                    if (sq_done) begin
                        r_nb <= r_nb + NBW'(1);
                        if (at_end) begin
                            r_oi    <= '0;
                            r_state <= S_ERD;
                        end else begin
                            r_j     <= r_j + AW'(1);
                            r_state <= S_RD;
                        end
                    end
                end
                S_EMPTY: begin
                    if (!r_ov) begin
                        r_ov     <= 1'b1;
                        r_o_idx  <= '0;
                        r_o_len  <= '0;
                        r_o_bv   <= 1'b0;
                        r_o_ovf  <= 1'b0;
                        r_o_last <= 1'b1;
                        r_state  <= S_IDLE;
                    end
                end
                S_ERD: r_state <= S_EWR;
                S_EWR: begin
                    if (!r_ov) begin
                        r_ov     <= 1'b1;
                        r_o_idx  <= r_buf_rd.idx;
                        r_o_len  <= r_buf_rd.len;
                        r_o_bv   <= 1'b1;
                        r_o_ovf  <= r_ovf;
                        r_o_last <= ((r_oi + NBW'(1)) == r_nb);
                        r_oi     <= r_oi + NBW'(1);
                        r_state  <= ((r_oi + NBW'(1)) == r_nb) ? S_IDLE : S_ERD;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out.valid          = r_ov;
    assign o_out.neighbor_index = r_o_idx;
    assign o_out.bond_length    = r_o_len;
    assign o_out.bond_valid     = r_o_bv;
    assign o_out.overflow       = r_o_ovf;
    assign o_out.last_bond      = r_o_last;

endmodule
`default_nettype wire

// File: test/bns_tb_if.sv
`timescale 1ns / 1ps
// The channel interfaces come with the block; this file only holds the bond record
// that the checker uses.
package bns_tb_pkg;
    import bns_pkg::*;

    typedef struct {
        logic [NIDX_W-1:0] idx;
        logic [LEN_W-1:0]  len;
        logic              bonded;
        logic              ovf;
        logic              last;
    } t_bond_word;
endpackage

// File: test/bns_checker.sv
`timescale 1ns / 1ps
module bns_checker (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    bns_in_if         i_in,
    bns_out_if        o_out,
    input  wire logic [9:0] i_scale,
    output int        o_fail_count,
    output int        o_pending
);
    import bns_pkg::*;
    import bns_tb_pkg::*;

    localparam int ATOM_CAP = 1024;
    localparam int BOND_CAP = 16;

    t_coord     atom_x [ATOM_CAP];
    t_coord     atom_y [ATOM_CAP];
    t_coord     atom_z [ATOM_CAP];
    t_radius    atom_r [ATOM_CAP];
    int         n_atoms;
    t_bond_word bonds_due [$];

    function automatic longint unsigned root_floor(longint unsigned v);
        longint unsigned res, bitv;
        res  = 0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv >>= 2;
        while (bitv != 0) begin
            if (v >= res + bitv) begin
                v   -= res + bitv;
                res  = (res >> 1) + bitv;
            end else begin
                res >>= 1;
            end
            bitv >>= 2;
        end
        return res;
    endfunction

    function automatic longint unsigned sq_gap(t_coord a, t_coord b);
        longint d;
        d = longint'(a) - longint'(b);
        if (d < 0) d = -d;
        return longint'(d) * longint'(d);
    endfunction

    task automatic search_bonds(int qi);
        longint unsigned d2, s, len;
        int              nb;
        bit              ovf;
        t_bond_word      w;
        t_bond_word      found [$];
        nb  = 0;
        ovf = 0;
        if (qi < n_atoms) begin
            for (int j = 0; j < n_atoms; j++) begin
                if (j == qi) continue;
                d2 = sq_gap(atom_x[qi], atom_x[j]) + sq_gap(atom_y[qi], atom_y[j])
                   + sq_gap(atom_z[qi], atom_z[j]);
                s = longint'(i_scale) * (longint'(atom_r[qi]) + longint'(atom_r[j]));
                if ((d2 << 16) >= s * s) continue;
                if (nb >= BOND_CAP) begin
                    ovf = 1;
                    continue;
                end
                len = root_floor(d2);
                if (len > 64'hFFFFF) len = 64'hFFFFF;
                w.idx = j[9:0]; w.len = len[19:0]; w.bonded = 1; w.ovf = 0; w.last = 0;
                found.push_back(w);
                nb++;
            end
        end
        if (nb == 0) begin
            w.idx = '0; w.len = '0; w.bonded = 0; w.ovf = 0; w.last = 1;
            found.push_back(w);
        end else begin
            foreach (found[k]) found[k].ovf = ovf;
            found[nb-1].last = 1;
        end
        foreach (found[k]) bonds_due.push_back(found[k]);
    endtask

    always @(posedge i_clk) begin
        t_bond_word e;
        if (!i_rst_n) begin
            n_atoms      <= 0;
            o_fail_count <= 0;
            o_pending    <= 0;
        end else begin
            if (i_in.valid && i_in.ready) begin
                case (i_in.mode)
                    MODE_APPEND: if (n_atoms < ATOM_CAP) begin
                        atom_x[n_atoms] = i_in.pos_x;
                        atom_y[n_atoms] = i_in.pos_y;
                        atom_z[n_atoms] = i_in.pos_z;
                        atom_r[n_atoms] = i_in.atom_radius;
                        n_atoms <= n_atoms + 1;
                    end
                    MODE_CLEAR: n_atoms <= 0;
                    MODE_QUERY: search_bonds(int'(i_in.query_index));
                    default: ;
                endcase
            end
            if (o_out.valid && o_out.ready) begin
                if (bonds_due.size() == 0) begin
                    o_fail_count <= o_fail_count + 1;
                    if (o_fail_count < 10)
                        $display("unexpected word idx=%0d len=%0d", o_out.neighbor_index,
                                 o_out.bond_length);
                end else begin
                    e = bonds_due.pop_front();
                    if (e.idx !== o_out.neighbor_index || e.len !== o_out.bond_length ||
                        e.bonded !== o_out.bond_valid || e.ovf !== o_out.overflow ||
                        e.last !== o_out.last_bond) begin
                        o_fail_count <= o_fail_count + 1;
                        if (o_fail_count < 10) begin
                            $display("mismatch exp idx=%0d len=%0d b=%0b o=%0b l=%0b",
                                     e.idx, e.len, e.bonded, e.ovf, e.last);
                            $display("         got idx=%0d len=%0d b=%0b o=%0b l=%0b",
                                     o_out.neighbor_index, o_out.bond_length,
                                     o_out.bond_valid, o_out.overflow, o_out.last_bond);
                        end
                    end
                end
            end
            o_pending <= bonds_due.size();
        end
    end
endmodule

// File: test/tb_bond_neighbor_search.sv
`timescale 1ns / 1ps
module tb_bond_neighbor_search;
    import bns_pkg::*;

    logic i_clk = 0;
    logic i_rst_n = 0;
    logic psel = 0, penable = 0, pwrite = 0;
    logic [PADDR_W-1:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic [9:0]  scale_now = SCALE_RESET;
    int          fail_count, pending;
    int          send_idle = 0, take_idle = 0;
    int          quiet_cycles = 0;

    bns_in_if  in_ch ();
    bns_out_if out_ch ();

    bond_neighbor_search dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in(in_ch.sink), .o_out(out_ch.source),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    bns_checker chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in(in_ch), .o_out(out_ch),
        .i_scale(scale_now), .o_fail_count(fail_count), .o_pending(pending)
    );

    always begin
        #6 i_clk = 1;
        #6 i_clk = 0;
    end

    initial begin
        in_ch.valid = 0; in_ch.mode = '0; in_ch.pos_x = '0; in_ch.pos_y = '0;
        in_ch.pos_z = '0; in_ch.atom_radius = '0; in_ch.query_index = '0;
        out_ch.ready = 0;
    end

    // receiver stall, redrawn every cycle
    always @(posedge i_clk)
        out_ch.ready <= ($urandom_range(99) >= take_idle);

    // watchdog: cycles with no word moving on either channel
    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > 200000) begin
            $display("[bond_neighbor_search] ERROR");
            $finish;
        end
    end

    // valid is left high after a handshake; the next call replaces or drops it
    task automatic send(t_mode m, int x, int y, int z, int r, int q);
        while ($urandom_range(99) < send_idle) begin
            in_ch.valid <= 0;
            @(posedge i_clk);
        end
        in_ch.valid       <= 1;
        in_ch.mode        <= m;
        in_ch.pos_x       <= x[19:0];
        in_ch.pos_y       <= y[19:0];
        in_ch.pos_z       <= z[19:0];
        in_ch.atom_radius <= r[11:0];
        in_ch.query_index <= q[9:0];
        do @(posedge i_clk); while (!in_ch.ready);
    endtask

    task automatic write_scale(int s);
        in_ch.valid <= 0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        psel <= 1; pwrite <= 1; paddr <= '0; pwdata <= 32'(s);
        @(posedge i_clk);
        penable <= 1;
        @(posedge i_clk);
        scale_now <= s[9:0];
        psel <= 0; penable <= 0; pwrite <= 0;
        @(posedge i_clk);
    endtask

    // clustered atoms so bonds are common; a few far ones for spread
    task automatic add_atom();
        if ($urandom_range(9) == 0)
            send(MODE_APPEND, $urandom, $urandom, $urandom, $urandom, $urandom);
        else
            send(MODE_APPEND, $urandom_range(1200) - 600, $urandom_range(1200) - 600,
                 $urandom_range(1200) - 600, $urandom_range(400, 100), $urandom);
    endtask

    task automatic random_phase(int n);
        int count;
        count = 0;
        for (int k = 0; k < n; k++) begin
            int pick;
            pick = $urandom_range(99);
            if (pick < 55 && count < 60) begin
                add_atom(); count++;
            end else if (pick < 92) begin
                send(MODE_QUERY, 0, 0, 0, 0,
                     $urandom_range(3) == 0 ? $urandom : $urandom_range(count));
            end else if (pick < 96) begin
                send(MODE_CLEAR, 0, 0, 0, 0, 0); count = 0;
            end else begin
                send(2'd3, $urandom, $urandom, $urandom, $urandom, $urandom);
            end
        end
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // extremes of fields and each special case
        send(MODE_QUERY, 0, 0, 0, 0, 0);                        // empty store
        send(MODE_APPEND, 524287, 524287, 524287, 4095, 1023);
        send(MODE_APPEND, -524288, -524288, -524288, 4095, 0);
        send(MODE_QUERY, 0, 0, 0, 0, 0);                        // huge distance, out of bond range
        send(MODE_QUERY, 0, 0, 0, 0, 1023);                     // index out of range
        send(2'd3, -1, -1, -1, 4095, 1023);                     // unused mode
        send(MODE_CLEAR, 0, 0, 0, 0, 0);
        for (int k = 0; k < 19; k++)                            // overflow: 18 bonded neighbours
            send(MODE_APPEND, k, -k, 2 * k, 256, 0);
        send(MODE_QUERY, 0, 0, 0, 0, 0);
        send(MODE_QUERY, 0, 0, 0, 0, 18);
        send(MODE_APPEND, 0, 0, 0, 0, 0);                       // coincident, zero radius
        send(MODE_QUERY, 0, 0, 0, 0, 19);

        write_scale(0);
        send(MODE_QUERY, 0, 0, 0, 0, 5);
        write_scale(1023);
        send(MODE_QUERY, 0, 0, 0, 0, 5);
        send(MODE_CLEAR, 0, 0, 0, 0, 0);

        send_idle = 10; take_idle = 86;
        write_scale(256);
        random_phase(132);
        send_idle = 86; take_idle = 10;
        write_scale($urandom_range(1023));
        random_phase(132);
        send_idle = 0; take_idle = 0;
        write_scale($urandom_range(400, 200));
        random_phase(132);

        in_ch.valid <= 0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        if (fail_count == 0)
            $display("[bond_neighbor_search] OK");
        else
            $display("[bond_neighbor_search] ERROR");
        $finish;
    end
endmodule

// File: sim.f
sv/bns_pkg.sv
sv/bns_if.sv
sv/bns_atom_store.sv
sv/bns_isqrt.sv
sv/bond_neighbor_search.sv
test/bns_tb_if.sv
test/bns_checker.sv
test/tb_bond_neighbor_search.sv
